>>> design/cba_pkg.sv
// Shared definitions for the contiguous block allocator.
// Holds field widths, status and register codes, and controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cba_pkg;

    // Default pool geometry.
    localparam int DEF_NUM_BLOCKS  = 64;
    localparam int DEF_MAX_RECORDS = 16;

    // Field widths fixed by the interface.
    localparam int BYTES_W  = 19;
    localparam int OFFSET_W = 18;
    localparam int STATUS_W = 3;
    localparam int BLKIDX_W = 6;
    localparam int SHIFT_W  = 4;
    localparam int RESV_W   = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SHIFT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RESERVED    = 1'd1;

    // Configuration reset values.
    localparam logic [SHIFT_W-1:0] RST_BLOCK_SHIFT = 4'd6;
    localparam logic [RESV_W-1:0]  RST_RESERVED    = 7'd2;

    // Request types.
    localparam logic REQ_ALLOC   = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NO_RUN     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_BIG    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd4;

    // Source of the block index in a result.
    typedef enum logic [1:0] {
        SRC_ZERO,
        SRC_ALLOC,
        SRC_REL
    } res_src_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                load_req;
        logic                scan_step;
        logic                find_step;
        logic                mark_step;
        logic                rec_write;
        logic                rel_step;
        logic                clr_init;
        logic                clr_step;
        logic                rel_commit;
        logic                res_set;
        logic [STATUS_W-1:0] res_code;
        res_src_t            res_src;
        logic                out_load;
    } cba_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_release;
        logic too_big;
        logic reserved_full;
        logic scan_hit;
        logic scan_last;
        logic find_hit;
        logic find_last;
        logic walk_last;
        logic rel_match;
        logic rel_last;
        logic out_free;
    } cba_stat_t;

endpackage

`default_nettype wire

>>> design/contiguous_block_allocator.sv
// Top level of the contiguous block allocator.
// Instantiates cba_ctrl and cba_datapath; uses cba_pkg.
//
//  Channel  Handshake            Payload
//  -------  -------------------  ---------------------------------------
//  in       in_valid / in_stall  req_type, alloc_bytes, free_offset
//  out      out_valid/out_stall  status, block_index, byte_offset
//  cfg      cfg_we               cfg_addr, cfg_wdata (write only)
//
// One request is handled at a time. An allocate scans the used bits downward one per
// cycle (at most NUM_BLOCKS - reserved_blocks) for a free run, probes the records one
// per cycle for a free slot, then marks the run's blocks one per cycle. A release
// probes each record through the registered record memory port in an address and a
// compare state, then clears the record's blocks one per cycle.
// Reset clears the used and live bits at once; the record memory needs no clearing.
// The output register lets the next transaction be taken while a result waits.
`timescale 1ns / 1ps
`default_nettype none

module contiguous_block_allocator #(
    parameter int NUM_BLOCKS  = cba_pkg::DEF_NUM_BLOCKS,
    parameter int MAX_RECORDS = cba_pkg::DEF_MAX_RECORDS
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             cfg_we,
    input  wire  [cba_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  wire  [cba_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire                             in_valid,
    output logic                            in_stall,
    input  wire                             req_type,
    input  wire  [cba_pkg::BYTES_W-1:0]     alloc_bytes,
    input  wire  [cba_pkg::OFFSET_W-1:0]    free_offset,
    output logic                            out_valid,
    input  wire                             out_stall,
    output logic [cba_pkg::STATUS_W-1:0]    status,
    output logic [cba_pkg::BLKIDX_W-1:0]    block_index,
    output logic [cba_pkg::OFFSET_W-1:0]    byte_offset
);
    import cba_pkg::*;

    cba_cmd_t  cmd;
    cba_stat_t stat;

    // Sequencing.
    cba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Storage and arithmetic.
    cba_datapath #(
        .NUM_BLOCKS  (NUM_BLOCKS),
        .MAX_RECORDS (MAX_RECORDS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .req_type    (req_type),
        .alloc_bytes (alloc_bytes),
        .free_offset (free_offset),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .block_index (block_index),
        .byte_offset (byte_offset),
        .cmd         (cmd),
        .stat        (stat)
    );

    // A transaction taken at the input keeps the block busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken again right after a transaction");

    // A failed request reports block zero at offset zero.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != ST_OK)) |-> ((block_index == '0) && (byte_offset == '0)))
        else $error("failed request carries a nonzero block");

    // Marking and clearing of used bits never overlap.
    a_mark_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.mark_step && cmd.clr_step))
        else $error("used bits marked and cleared in the same cycle");

endmodule

`default_nettype wire

>>> design/cba_ctrl.sv
// Controller state machine of the contiguous block allocator.
// Sequences scan, record search, marking and release; depends on cba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cba_ctrl (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               in_valid,
    output logic              in_stall,
    input  cba_pkg::cba_stat_t stat,
    output cba_pkg::cba_cmd_t  cmd
);
    import cba_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_CHECK    = 4'd1;
    localparam logic [3:0] S_SCAN     = 4'd2;
    localparam logic [3:0] S_FIND     = 4'd3;
    localparam logic [3:0] S_MARK     = 4'd4;
    localparam logic [3:0] S_REL_ADDR = 4'd5;
    localparam logic [3:0] S_REL_CMP  = 4'd6;
    localparam logic [3:0] S_CLEAR    = 4'd7;
    localparam logic [3:0] S_RESULT   = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and command decode.
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.res_src  = SRC_ZERO;
        in_stall     = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.is_release)
                begin
                    state_next = S_REL_ADDR;
                end
                else if (stat.too_big)
                begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = ST_TOO_BIG;
                    state_next   = S_RESULT;
                end
                else if (stat.reserved_full)
                begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = ST_NO_RUN;
                    state_next   = S_RESULT;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_hit)
                begin
                    state_next = S_FIND;
                end
                else if (stat.scan_last)
                begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = ST_NO_RUN;
                    state_next   = S_RESULT;
                end
            end
            S_FIND:
            begin
                if (stat.find_hit)
                begin
                    state_next = S_MARK;
                end
                else if (stat.find_last)
                begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = ST_TABLE_FULL;
                    state_next   = S_RESULT;
                end
                else
                begin
                    cmd.find_step = 1'b1;
                end
            end
            S_MARK:
            begin
                cmd.mark_step = 1'b1;
                if (stat.walk_last)
                begin
                    cmd.rec_write = 1'b1;
                    cmd.res_set   = 1'b1;
                    cmd.res_code  = ST_OK;
                    cmd.res_src   = SRC_ALLOC;
                    state_next    = S_RESULT;
                end
            end
            S_REL_ADDR:
            begin
                // The record memory read settles during this cycle.
                state_next = S_REL_CMP;
            end
            S_REL_CMP:
            begin
                if (stat.rel_match)
                begin
                    cmd.clr_init = 1'b1;
                    state_next   = S_CLEAR;
                end
                else if (stat.rel_last)
                begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = ST_NOT_FOUND;
                    state_next   = S_RESULT;
                end
                else
                begin
                    cmd.rel_step = 1'b1;
                    state_next   = S_REL_ADDR;
                end
            end
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.walk_last)
                begin
                    cmd.rel_commit = 1'b1;
                    cmd.res_set    = 1'b1;
                    cmd.res_code   = ST_OK;
                    cmd.res_src    = SRC_REL;
                    state_next     = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> design/cba_datapath.sv
// Datapath of the contiguous block allocator: configuration, used bits,
// record table, scan and walk counters, and the output register. Uses cba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cba_datapath #(
    parameter int NUM_BLOCKS  = cba_pkg::DEF_NUM_BLOCKS,
    parameter int MAX_RECORDS = cba_pkg::DEF_MAX_RECORDS
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 cfg_we,
    input  wire  [cba_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  wire  [cba_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  wire                                 req_type,
    input  wire  [cba_pkg::BYTES_W-1:0]         alloc_bytes,
    input  wire  [cba_pkg::OFFSET_W-1:0]        free_offset,
    output logic                                out_valid,
    input  wire                                 out_stall,
    output logic [cba_pkg::STATUS_W-1:0]        status,
    output logic [cba_pkg::BLKIDX_W-1:0]        block_index,
    output logic [cba_pkg::OFFSET_W-1:0]        byte_offset,
    input  cba_pkg::cba_cmd_t                   cmd,
    output cba_pkg::cba_stat_t                  stat
);
    import cba_pkg::*;

    localparam int IW  = $clog2(NUM_BLOCKS);
    localparam int NW  = $clog2(NUM_BLOCKS + 1);
    localparam int RW  = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int SHW = (IW + 15 > OFFSET_W) ? IW + 15 : OFFSET_W;
    localparam int CW  = (IW + 1 > RESV_W) ? IW + 1 : RESV_W;
    localparam int SUMW = BYTES_W + 1;

    localparam logic [IW-1:0]   TOP_BLOCK   = IW'(NUM_BLOCKS - 1);
    localparam logic [RW-1:0]   LAST_REC    = RW'(MAX_RECORDS - 1);
    localparam logic [SUMW-1:0] POOL_BLOCKS = SUMW'(NUM_BLOCKS);
    localparam logic [CW-1:0]   POOL_CMP    = CW'(NUM_BLOCKS);

    // Configuration registers.
    logic [SHIFT_W-1:0] blk_shift_reg;
    logic [RESV_W-1:0]  reserved_reg;

    // Captured request.
    logic                req_type_reg;
    logic                too_big_reg;
    logic [NW-1:0]       need_reg;
    logic [OFFSET_W-1:0] free_offset_reg;

    // Pool and record state.
    logic [NUM_BLOCKS-1:0]  used_reg;
    logic [MAX_RECORDS-1:0] live_reg;
    logic [2*IW-1:0]        rec_mem [MAX_RECORDS];
    logic [2*IW-1:0]        rd_reg;

    // Counters.
    logic [IW-1:0] scan_i_reg;
    logic [NW-1:0] run_reg;
    logic [RW-1:0] rec_idx_reg;
    logic [IW-1:0] walk_i_reg;
    logic [IW-1:0] walk_end_reg;
    logic [IW-1:0] alloc_start_reg;

    // Pending result.
    logic [STATUS_W-1:0] pend_status_reg;
    logic [IW-1:0]       pend_blk_reg;

    // Output register.
    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [BLKIDX_W-1:0] out_blk_reg;
    logic [OFFSET_W-1:0] out_byte_reg;

    logic [SUMW-1:0] round_sum;
    logic [SUMW-1:0] need_full;
    logic [NW-1:0]   run_inc;
    logic [NW:0]     run_end;
    logic [IW-1:0]   rd_start;
    logic [IW-1:0]   rd_end;
    logic [SHW-1:0]  rd_shifted;
    logic [SHW-1:0]  pend_ext;
    logic [SHW-1:0]  pend_shifted;
    logic            out_free;

    // Block count needed for the request, rounded up.
    assign round_sum = SUMW'(alloc_bytes) + ((SUMW'(1) << blk_shift_reg) - SUMW'(1));
    assign need_full = round_sum >> blk_shift_reg;

    assign run_inc  = run_reg + NW'(1);
    assign run_end  = (NW + 1)'(scan_i_reg) + (NW + 1)'(need_reg) - (NW + 1)'(1);
    assign rd_start = rd_reg[2*IW-1:IW];
    assign rd_end   = rd_reg[IW-1:0];
    assign rd_shifted   = SHW'(rd_start) << blk_shift_reg;
    assign pend_ext     = SHW'(pend_blk_reg);
    assign pend_shifted = pend_ext << blk_shift_reg;
    assign out_free     = !out_valid_reg || !out_stall;

    // Status toward the controller.
    always_comb
    begin
        stat.is_release    = (req_type_reg == REQ_RELEASE);
        stat.too_big       = too_big_reg;
        stat.reserved_full = (CW'(reserved_reg) >= POOL_CMP);
        stat.scan_hit      = !used_reg[scan_i_reg] && (run_inc == need_reg);
        stat.scan_last     = (scan_i_reg == '0) || (CW'(scan_i_reg) == CW'(reserved_reg));
        stat.find_hit      = !live_reg[rec_idx_reg];
        stat.find_last     = (rec_idx_reg == LAST_REC);
        stat.walk_last     = (walk_i_reg == walk_end_reg);
        stat.rel_match     = live_reg[rec_idx_reg] && (rd_shifted == SHW'(free_offset_reg));
        stat.rel_last      = (rec_idx_reg == LAST_REC);
        stat.out_free      = out_free;
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_shift_reg <= RST_BLOCK_SHIFT;
            reserved_reg  <= RST_RESERVED;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_BLOCK_SHIFT: blk_shift_reg <= cfg_wdata[SHIFT_W-1:0];
                REG_RESERVED:    reserved_reg  <= cfg_wdata[RESV_W-1:0];
                default:         ;
            endcase
        end
    end

    // Request capture, counters and pending result.
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_type_reg    <= req_type;
            free_offset_reg <= free_offset;
            too_big_reg     <= (need_full > POOL_BLOCKS);
            need_reg        <= (need_full == '0) ? NW'(1) : need_full[NW-1:0];
            scan_i_reg      <= TOP_BLOCK;
            run_reg         <= '0;
            rec_idx_reg     <= '0;
        end
        if (cmd.scan_step)
        begin
            run_reg    <= used_reg[scan_i_reg] ? '0 : run_inc;
            scan_i_reg <= scan_i_reg - IW'(1);
            if (stat.scan_hit)
            begin
                alloc_start_reg <= scan_i_reg;
                walk_i_reg      <= scan_i_reg;
                walk_end_reg    <= run_end[IW-1:0];
            end
        end
        if (cmd.find_step || cmd.rel_step)
        begin
            rec_idx_reg <= rec_idx_reg + RW'(1);
        end
        if (cmd.clr_init)
        begin
            walk_i_reg   <= rd_start;
            walk_end_reg <= rd_end;
        end
        if (cmd.mark_step || cmd.clr_step)
        begin
            walk_i_reg <= walk_i_reg + IW'(1);
        end
        if (cmd.res_set)
        begin
            pend_status_reg <= cmd.res_code;
            case (cmd.res_src)
                SRC_ALLOC: pend_blk_reg <= alloc_start_reg;
                SRC_REL:   pend_blk_reg <= rd_start;
                default:   pend_blk_reg <= '0;
            endcase
        end
    end

    // Used bits: set while marking, cleared while releasing.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else if (cmd.mark_step)
        begin
            used_reg[walk_i_reg] <= 1'b1;
        end
        else if (cmd.clr_step)
        begin
            used_reg[walk_i_reg] <= 1'b0;
        end
    end

    // Live bits of the record table.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= '0;
        end
        else if (cmd.rec_write)
        begin
            live_reg[rec_idx_reg] <= 1'b1;
        end
        else if (cmd.rel_commit)
        begin
            live_reg[rec_idx_reg] <= 1'b0;
        end
    end

    // Record memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.rec_write)
        begin
            rec_mem[rec_idx_reg] <= {alloc_start_reg, walk_end_reg};
        end
        rd_reg <= rec_mem[rec_idx_reg];
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_status_reg <= pend_status_reg;
            out_blk_reg    <= pend_ext[BLKIDX_W-1:0];
            out_byte_reg   <= pend_shifted[OFFSET_W-1:0];
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign block_index = out_blk_reg;
    assign byte_offset = out_byte_reg;

endmodule

`default_nettype wire
